// ===== hdl/sbqf_pkg.sv =====
// Shared types and constants for the stereo biquad filter.
package sbqf_pkg;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_FRAC_BITS = 16;

  localparam int COEF_W  = 20;
  localparam int GAIN_W  = 18;
  localparam int NUM_CH  = 2;
  localparam int HIST_N  = 4;

  // intermediate sum is clamped to +-2^CLAMP_LOG before the gain multiply
  localparam int CLAMP_LOG = 44;
  localparam int CLAMP_W   = CLAMP_LOG + 2;
  // clamped sum is multiplied by gain in two halves split at this bit
  localparam int SPLIT     = 23;
  localparam int GACC_W    = 65;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_A0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd5;

  localparam logic signed [COEF_W-1:0] A0_RST   = 20'sd65536;
  localparam logic [GAIN_W-1:0]        GAIN_RST = 18'd58982;

  localparam int STEP_W = 3;

  // multiply-accumulate terms, one per step
  localparam logic [STEP_W-1:0] TERM_A0  = 3'd0;
  localparam logic [STEP_W-1:0] TERM_A1  = 3'd1;
  localparam logic [STEP_W-1:0] TERM_A2  = 3'd2;
  localparam logic [STEP_W-1:0] TERM_B1  = 3'd3;
  localparam logic [STEP_W-1:0] TERM_B2  = 3'd4;
  localparam logic [STEP_W-1:0] MAC_LAST = 3'd5;

  // gain multiply steps
  localparam logic [STEP_W-1:0] GAIN_LO  = 3'd0;
  localparam logic [STEP_W-1:0] GAIN_HI  = 3'd1;
  localparam logic [STEP_W-1:0] GAIN_SUM = 3'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_READ,
    PH_MAC,
    PH_ROUND,
    PH_CLAMP,
    PH_GAIN,
    PH_SAT,
    PH_WB
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [STEP_W-1:0] step;
    logic              accept;
    logic              wb;
  } ctrl_t;

endpackage

// ===== hdl/sbqf_if.sv =====
// Handshake channel interfaces: audio input, filtered output, configuration writes.
interface sbqf_in_if #(parameter int SW = sbqf_pkg::SAMPLE_WIDTH);
  logic                 valid;
  logic                 ready;
  logic                 channel;
  logic signed [SW-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface sbqf_out_if #(parameter int SW = sbqf_pkg::SAMPLE_WIDTH);
  logic                 valid;
  logic                 ready;
  logic                 out_channel;
  logic signed [SW-1:0] filtered;

  modport source (output valid, output out_channel, output filtered, input ready);
  modport sink (input valid, input out_channel, input filtered, output ready);
endinterface

interface sbqf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sbqf_pkg::CFG_IDX_W-1:0]      index;
  logic [sbqf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/stereo_biquad_lowpass_filter_core.sv =====
// Two-channel direct-form-I biquad with per-channel history held in a RAM.
// A request passes the read, multiply-accumulate, round, clamp, gain and saturation
// phases, then waits in write-back while the output register is held by the sink.
// A new request is taken only after write-back, as the five-term multiply-
// accumulate and the two-part gain multiply share one multiplier.
// Reset: coefficients take their defaults and both channels' history reads as zero.
module stereo_biquad_lowpass_filter_core #(
  parameter int SAMPLE_WIDTH   = sbqf_pkg::SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = sbqf_pkg::COEF_FRAC_BITS
) (
  input logic         clk,
  input logic         rst,
  sbqf_in_if.sink     audio,
  sbqf_out_if.source  result,
  sbqf_cfg_if.sink    cfg
);

  localparam int ROW_W = sbqf_pkg::HIST_N * SAMPLE_WIDTH;

  sbqf_pkg::ctrl_t                         ctrl;
  logic                                    channel;
  logic                                    out_free;
  logic [sbqf_pkg::NUM_CH-1:0]             hist_valid;
  logic                                    row_valid;
  logic [ROW_W-1:0]                        row, wr_row;
  logic signed [SAMPLE_WIDTH-1:0]          y;
  logic signed [sbqf_pkg::COEF_W-1:0]      coef_a0, coef_a1, coef_a2, coef_b1, coef_b2;
  logic [sbqf_pkg::GAIN_W-1:0]             output_gain;
  logic                                    out_valid;
  logic                                    out_channel;
  logic signed [SAMPLE_WIDTH-1:0]          filtered;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a0     <= sbqf_pkg::A0_RST;
      coef_a1     <= '0;
      coef_a2     <= '0;
      coef_b1     <= '0;
      coef_b2     <= '0;
      output_gain <= sbqf_pkg::GAIN_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        sbqf_pkg::REG_A0:   coef_a0     <= cfg.data;
        sbqf_pkg::REG_A1:   coef_a1     <= cfg.data;
        sbqf_pkg::REG_A2:   coef_a2     <= cfg.data;
        sbqf_pkg::REG_B1:   coef_b1     <= cfg.data;
        sbqf_pkg::REG_B2:   coef_b2     <= cfg.data;
        sbqf_pkg::REG_GAIN: output_gain <= cfg.data[sbqf_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sbqf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (audio.valid),
    .in_channel (audio.channel),
    .out_free   (out_free),
    .in_ready   (audio.ready),
    .channel    (channel),
    .ctrl       (ctrl)
  );

  sbqf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (sbqf_pkg::NUM_CH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ctrl.wb),
    .waddr (channel),
    .wdata (wr_row),
    .re    (ctrl.phase == sbqf_pkg::PH_READ),
    .raddr (channel),
    .rdata (row)
  );

  // row valid bits stand in for clearing the history at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (ctrl.wb) begin
      hist_valid[channel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.phase == sbqf_pkg::PH_READ) begin
      row_valid <= hist_valid[channel];
    end
  end

  sbqf_dp #(
    .SW (SAMPLE_WIDTH),
    .F  (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .sample    (audio.sample),
    .row       (row),
    .row_valid (row_valid),
    .coef_a0   (coef_a0),
    .coef_a1   (coef_a1),
    .coef_a2   (coef_a2),
    .coef_b1   (coef_b1),
    .coef_b2   (coef_b2),
    .gain      (output_gain),
    .wr_row    (wr_row),
    .y         (y)
  );

  // output register
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.wb) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wb) begin
      out_channel <= channel;
      filtered    <= y;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_channel = out_channel;
  assign result.filtered    = filtered;

endmodule

// ===== hdl/sbqf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbqf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sbqf_ctrl.sv =====
// Sequencer: accepts a request, steps the datapath through its phases, writes back.
module sbqf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_channel,
  input  logic            out_free,
  output logic            in_ready,
  output logic            channel,
  output sbqf_pkg::ctrl_t ctrl
);

  sbqf_pkg::phase_t                phase, phase_next;
  logic [sbqf_pkg::STEP_W-1:0]     step, step_next;
  logic                            accept, wb;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sbqf_pkg::PH_IDLE;
      step  <= '0;
    end else begin
      phase <= phase_next;
      step  <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      channel <= in_channel;
    end
  end

  always_comb begin
    phase_next = phase;
    step_next  = step;
    in_ready   = 1'b0;
    accept     = 1'b0;
    wb         = 1'b0;
    case (phase)
      sbqf_pkg::PH_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          accept     = 1'b1;
          phase_next = sbqf_pkg::PH_READ;
        end
      end
      sbqf_pkg::PH_READ: begin
        step_next  = '0;
        phase_next = sbqf_pkg::PH_MAC;
      end
      sbqf_pkg::PH_MAC: begin
        if (step == sbqf_pkg::MAC_LAST) begin
          step_next  = '0;
          phase_next = sbqf_pkg::PH_ROUND;
        end else begin
          step_next = step + 1'b1;
        end
      end
      sbqf_pkg::PH_ROUND: begin
        phase_next = sbqf_pkg::PH_CLAMP;
      end
      sbqf_pkg::PH_CLAMP: begin
        step_next  = '0;
        phase_next = sbqf_pkg::PH_GAIN;
      end
      sbqf_pkg::PH_GAIN: begin
        if (step == sbqf_pkg::GAIN_SUM) begin
          step_next  = '0;
          phase_next = sbqf_pkg::PH_SAT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      sbqf_pkg::PH_SAT: begin
        phase_next = sbqf_pkg::PH_WB;
      end
      sbqf_pkg::PH_WB: begin
        // hold until the output register can take the result
        if (out_free) begin
          wb         = 1'b1;
          phase_next = sbqf_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = sbqf_pkg::PH_IDLE;
      end
    endcase
  end

  assign ctrl.phase  = phase;
  assign ctrl.step   = step;
  assign ctrl.accept = accept;
  assign ctrl.wb     = wb;

endmodule

// ===== hdl/sbqf_dp.sv =====
// Arithmetic datapath: shared multiplier, accumulator, rounding, clamp, gain and saturation.
module sbqf_dp #(
  parameter int SW = sbqf_pkg::SAMPLE_WIDTH,
  parameter int F  = sbqf_pkg::COEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  sbqf_pkg::ctrl_t                      ctrl,
  input  logic signed [SW-1:0]                 sample,
  input  logic [sbqf_pkg::HIST_N*SW-1:0]       row,
  input  logic                                 row_valid,
  input  logic signed [sbqf_pkg::COEF_W-1:0]   coef_a0,
  input  logic signed [sbqf_pkg::COEF_W-1:0]   coef_a1,
  input  logic signed [sbqf_pkg::COEF_W-1:0]   coef_a2,
  input  logic signed [sbqf_pkg::COEF_W-1:0]   coef_b1,
  input  logic signed [sbqf_pkg::COEF_W-1:0]   coef_b2,
  input  logic [sbqf_pkg::GAIN_W-1:0]          gain,
  output logic [sbqf_pkg::HIST_N*SW-1:0]       wr_row,
  output logic signed [SW-1:0]                 y
);

  localparam int MA     = (SW > sbqf_pkg::SPLIT + 1) ? SW : sbqf_pkg::SPLIT + 1;
  localparam int CW     = sbqf_pkg::COEF_W;
  localparam int PROD_W = MA + CW;
  localparam int ACC_W  = SW + CW + 3;
  localparam int RND_W  = ACC_W + 1 - F;
  localparam int S_W    = (RND_W > sbqf_pkg::CLAMP_W) ? RND_W : sbqf_pkg::CLAMP_W;
  localparam int HI_W   = sbqf_pkg::CLAMP_W - sbqf_pkg::SPLIT;
  localparam int GW     = sbqf_pkg::GACC_W;
  localparam int YW     = GW - F;

  localparam logic signed [ACC_W:0]  HALF  = (ACC_W + 1)'(1) << (F - 1);
  localparam logic signed [GW-1:0]   GHALF = GW'(1) << (F - 1);
  localparam logic signed [S_W-1:0]  LIM   = S_W'(1) << sbqf_pkg::CLAMP_LOG;
  localparam logic signed [S_W-1:0]  NLIM  = -LIM;
  localparam logic signed [YW-1:0]   MAXV  = (YW'(1) << (SW - 1)) - YW'(1);
  localparam logic signed [YW-1:0]   MINV  = -MAXV - YW'(1);

  logic signed [SW-1:0]                 x0;
  logic signed [SW-1:0]                 h_x1, h_x2, h_y1, h_y2;
  logic signed [MA-1:0]                 mul_a;
  logic signed [CW-1:0]                 mul_b;
  logic signed [PROD_W-1:0]             prod;
  logic signed [ACC_W-1:0]              acc;
  logic signed [ACC_W:0]                rnd;
  logic signed [RND_W-1:0]              s;
  logic signed [S_W-1:0]                s_ext;
  logic signed [sbqf_pkg::CLAMP_W-1:0]  c;
  logic signed [HI_W-1:0]               c_hi;
  logic signed [GW-1:0]                 gacc;
  logic signed [YW-1:0]                 yw;

  // a row that was never written reads as zero history
  assign h_x1 = row_valid ? row[SW-1:0]      : '0;
  assign h_x2 = row_valid ? row[2*SW-1:SW]   : '0;
  assign h_y1 = row_valid ? row[3*SW-1:2*SW] : '0;
  assign h_y2 = row_valid ? row[4*SW-1:3*SW] : '0;

  // shift both histories by one place
  assign wr_row = {h_y1, y, h_x1, x0};

  assign c_hi  = c[sbqf_pkg::CLAMP_W-1:sbqf_pkg::SPLIT];
  assign rnd   = (ACC_W + 1)'(acc) + HALF;
  assign s_ext = S_W'(s);
  assign yw    = gacc[GW-1:F];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.phase)
      sbqf_pkg::PH_MAC: begin
        case (ctrl.step)
          sbqf_pkg::TERM_A0: begin
            mul_a = MA'(x0);
            mul_b = coef_a0;
          end
          sbqf_pkg::TERM_A1: begin
            mul_a = MA'(h_x1);
            mul_b = coef_a1;
          end
          sbqf_pkg::TERM_A2: begin
            mul_a = MA'(h_x2);
            mul_b = coef_a2;
          end
          sbqf_pkg::TERM_B1: begin
            mul_a = MA'(h_y1);
            mul_b = coef_b1;
          end
          sbqf_pkg::TERM_B2: begin
            mul_a = MA'(h_y2);
            mul_b = coef_b2;
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      sbqf_pkg::PH_GAIN: begin
        mul_b = CW'($signed({1'b0, gain}));
        case (ctrl.step)
          sbqf_pkg::GAIN_LO: mul_a = MA'($signed({1'b0, c[sbqf_pkg::SPLIT-1:0]}));
          sbqf_pkg::GAIN_HI: mul_a = MA'(c_hi);
          default:           mul_a = '0;
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      x0 <= sample;
    end
    prod <= mul_a * mul_b;
    case (ctrl.phase)
      sbqf_pkg::PH_READ: begin
        acc <= '0;
      end
      sbqf_pkg::PH_MAC: begin
        // accumulate the product issued one step earlier; feedback terms subtract
        if (ctrl.step > sbqf_pkg::TERM_B1) begin
          acc <= acc - ACC_W'(prod);
        end else if (ctrl.step != sbqf_pkg::TERM_A0) begin
          acc <= acc + ACC_W'(prod);
        end
      end
      sbqf_pkg::PH_ROUND: begin
        s <= rnd[ACC_W:F];
      end
      sbqf_pkg::PH_CLAMP: begin
        if (s_ext > LIM) begin
          c <= sbqf_pkg::CLAMP_W'(LIM);
        end else if (s_ext < NLIM) begin
          c <= sbqf_pkg::CLAMP_W'(NLIM);
        end else begin
          c <= sbqf_pkg::CLAMP_W'(s_ext);
        end
      end
      sbqf_pkg::PH_GAIN: begin
        if (ctrl.step == sbqf_pkg::GAIN_HI) begin
          gacc <= GW'(prod) + GHALF;
        end else if (ctrl.step == sbqf_pkg::GAIN_SUM) begin
          gacc <= gacc + (GW'(prod) <<< sbqf_pkg::SPLIT);
        end
      end
      sbqf_pkg::PH_SAT: begin
        if (yw > MAXV) begin
          y <= SW'(MAXV);
        end else if (yw < MINV) begin
          y <= SW'(MINV);
        end else begin
          y <= SW'(yw);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
